// ----- hw/rtl/bca_pkg.sv -----
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants of the bitmap cell allocator
// Operation kinds, status codes, config register indexes and bitmap word size.
// ----------------------------------------------------------------------------
`default_nettype none

package bca_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_FULL     = 2'd1;
    localparam t_status STATUS_BAD_FREE = 2'd2;

    typedef logic t_kind;
    localparam t_kind KIND_ALLOC = 1'b0;
    localparam t_kind KIND_FREE  = 1'b1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BASE_ADDRESS = 2'd0;
    localparam t_cfg_idx CFG_CELL_SIZE    = 2'd1;
    localparam t_cfg_idx CFG_CELL_COUNT   = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/bca_ram.sv -----
// ----------------------------------------------------------------------------
// bca_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bca_divider.sv -----
// ----------------------------------------------------------------------------
// bca_divider: iterative restoring divider, 32-bit by 16-bit
// One quotient bit per cycle; a zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bca_pkg::ADDR_W-1:0] i_dividend,
    input  wire logic [bca_pkg::SIZE_W-1:0] i_divisor,
    output logic                            o_done,
    output logic      [bca_pkg::ADDR_W-1:0] o_quotient
);

    import bca_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [ADDR_W-1:0] r_quo;
    logic [SIZE_W-1:0] r_div;
    logic              r_done;

    logic [SIZE_W:0]   w_shift;
    logic [SIZE_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[ADDR_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // borrow clear means the shifted remainder reached the divisor
                if (!w_diff[SIZE_W] || (r_div == '0)) begin
                    r_rem <= w_diff[SIZE_W-1:0];
                    r_quo <= {r_quo[ADDR_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[SIZE_W-1:0];
                    r_quo <= {r_quo[ADDR_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_cell_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_cell_allocator_top: fixed-size cell allocator with a usage bitmap
// Alloc: scans bitmap rows in order (32 cells per row, one RAM read per row) and
//   grants the lowest free cell; full if no row within the cell count has one.
// Free: 32-step divide to the cell index, then read-modify-write; bad free skips it.
// One transaction at a time: busy is high from accept until the result strobe.
// Synchronous active-low reset: state and config registers to defaults, all cells free.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_cell_allocator_top #(
    parameter int MAX_CELLS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic                          i_kind,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_cell_address,
    output logic                               o_valid,
    output logic      [bca_pkg::ADDR_W-1:0]    o_granted_address,
    output logic      [1:0]                    o_status,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_cfg_data
);

    import bca_pkg::*;

    localparam int ROWS   = (MAX_CELLS + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CIDX_W = ROW_W + BIT_W;
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_READ,
        S_A_CHECK,
        S_A_MUL,
        S_A_ADD,
        S_F_DIV,
        S_F_READ,
        S_F_CLEAR
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_base;
    logic [SIZE_W-1:0]  r_cell_size;
    logic [COUNT_W-1:0] r_cell_count;
    logic [ROWS-1:0]    r_row_vld;
    logic [ROW_W-1:0]   r_row;
    logic [CIDX_W-1:0]  r_cidx;
    logic [ADDR_W-1:0]  r_prod;
    logic               r_valid;
    logic [ADDR_W-1:0]  r_granted;
    t_status            r_status;

    logic               w_accept;
    logic               w_div_start;
    logic               w_div_done;
    logic [ADDR_W-1:0]  w_quot;
    logic [CNT_W-1:0]   w_active;
    logic [ADDR_W-1:0]  w_row_start;
    logic               w_row_live;
    logic [ADDR_W-1:0]  w_rem;
    logic [WORD_W-1:0]  w_mask;
    logic [WORD_W-1:0]  w_rdata;
    logic [WORD_W-1:0]  w_word;
    logic [WORD_W-1:0]  w_free;
    logic               w_found;
    logic [BIT_W-1:0]   w_bit;
    logic               w_last_row;
    logic               w_we;
    logic [WORD_W-1:0]  w_wdata;

    assign w_accept    = i_start && !o_busy;
    assign w_div_start = w_accept && (i_kind == KIND_FREE);

    // cell counts beyond the bitmap depth act as the full depth
    assign w_active = (32'(r_cell_count) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                           : CNT_W'(r_cell_count);

    bca_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_cell_address - r_base),
        .i_divisor  (r_cell_size),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    bca_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_raddr (r_row),
        .o_rdata (w_rdata)
    );

    // rows never written since reset read as all free
    assign w_word = r_row_vld[r_row] ? w_rdata : '0;

    assign w_row_start = 32'({r_row, BIT_W'(0)});
    assign w_row_live  = 32'(w_active) > w_row_start;
    assign w_rem       = 32'(w_active) - w_row_start;

    always_comb begin
        if (!w_row_live) begin
            w_mask = '0;
        end else if (w_rem >= 32'(WORD_W)) begin
            w_mask = '1;
        end else begin
            w_mask = (WORD_W'(1) << w_rem[BIT_W-1:0]) - WORD_W'(1);
        end
    end

    assign w_free  = ~w_word & w_mask;
    assign w_found = |w_free;

    // lowest free cell of the row
    always_comb begin
        w_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_bit = BIT_W'(b);
            end
        end
    end

    assign w_last_row = !w_row_live || (w_rem <= 32'(WORD_W)) ||
                        (32'(r_row) == 32'(ROWS - 1));

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_word;
        unique case (r_state)
            S_A_CHECK: begin
                w_we    = w_found;
                w_wdata = w_word | (WORD_W'(1) << w_bit);
            end
            S_F_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = w_word & ~(WORD_W'(1) << r_cidx[BIT_W-1:0]);
            end
            default: begin
                w_we    = 1'b0;
                w_wdata = w_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base       <= '0;
            r_cell_size  <= SIZE_W'(1);
            r_cell_count <= '0;
            r_row_vld    <= '0;
            r_row        <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BASE_ADDRESS: r_base       <= i_cfg_data;
                    CFG_CELL_SIZE:    r_cell_size  <= i_cfg_data[SIZE_W-1:0];
                    CFG_CELL_COUNT:   r_cell_count <= i_cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
            if (w_we) begin
                r_row_vld[r_row] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_row   <= '0;
                        r_state <= (i_kind == KIND_FREE) ? S_F_DIV : S_A_READ;
                    end
                end
                S_A_READ: begin
                    r_state <= S_A_CHECK;
                end
                S_A_CHECK: begin
                    if (w_found) begin
                        r_cidx  <= {r_row, w_bit};
                        r_state <= S_A_MUL;
                    end else if (w_last_row) begin
                        r_valid   <= 1'b1;
                        r_granted <= '0;
                        r_status  <= STATUS_FULL;
                        r_state   <= S_IDLE;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_state <= S_A_READ;
                    end
                end
                S_A_MUL: begin
                    r_prod  <= 32'(r_cidx) * 32'(r_cell_size);
                    r_state <= S_A_ADD;
                end
                S_A_ADD: begin
                    r_valid   <= 1'b1;
                    r_granted <= r_base + r_prod;
                    r_status  <= STATUS_OK;
                    r_state   <= S_IDLE;
                end
                S_F_DIV: begin
                    if (w_div_done) begin
                        if (w_quot < 32'(w_active)) begin
                            r_cidx  <= CIDX_W'(w_quot);
                            r_row   <= w_quot[CIDX_W-1:BIT_W];
                            r_state <= S_F_READ;
                        end else begin
                            r_valid   <= 1'b1;
                            r_granted <= '0;
                            r_status  <= STATUS_BAD_FREE;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                S_F_READ: begin
                    r_state <= S_F_CLEAR;
                end
                S_F_CLEAR: begin
                    r_valid   <= 1'b1;
                    r_granted <= '0;
                    r_status  <= STATUS_OK;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_granted_address = r_granted;
    assign o_status          = r_status;
    assign o_cfg_ready       = 1'b1;

endmodule

`default_nettype wire

// ----- hw/rtl/bca_checker.sv -----
// ----------------------------------------------------------------------------
// bca_checker: port-level checks of the bitmap cell allocator
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bca_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_start,
    input wire logic                          o_busy,
    input wire logic                          i_kind,
    input wire logic [bca_pkg::ADDR_W-1:0]    i_cell_address,
    input wire logic                          o_valid,
    input wire logic [bca_pkg::ADDR_W-1:0]    o_granted_address,
    input wire logic [1:0]                    o_status,
    input wire logic                          i_cfg_valid,
    input wire logic                          o_cfg_ready,
    input wire logic [bca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [bca_pkg::ADDR_W-1:0]    i_cfg_data
);

    import bca_pkg::*;

    // an accepted transaction keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk)
        (i_rst_n && i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after accepted transaction");

    // each transaction passes through busy states before its result strobe, so strobes never touch
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK || o_status == STATUS_FULL ||
                     o_status == STATUS_BAD_FREE))
        else $error("undefined status code");

    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STATUS_OK) |-> (o_granted_address == '0))
        else $error("address given with an error status");

    // a result is only reported while a transaction is finishing
    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without a transaction in flight");

endmodule

bind bitmap_cell_allocator_top bca_checker u_bca_checker (.*);

`default_nettype wire

// ----- dv/bitmap_cell_allocator_checker.sv -----
// ----------------------------------------------------------------------------
// bitmap_cell_allocator_checker: result prediction and compare for the allocator
// Watches the request, result and register write channels, keeps its own copy
// of the usage bitmap and registers, and compares every result strobe in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_cell_allocator_checker #(
    parameter int MAX_CELLS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_busy,
    input  wire logic                          i_kind,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_cell_address,
    input  wire logic                          i_valid,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_granted_address,
    input  wire logic [1:0]                    i_status,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [bca_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bca_pkg::ADDR_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    import bca_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        t_status           status;
    } t_alloc_result;

    t_alloc_result          expected_results[$];
    logic [ADDR_W-1:0]      base_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [MAX_CELLS-1:0]   used_cells;
    int                     fails = 0;

    // serves one request against the local bitmap and returns the outcome
    function automatic t_alloc_result serve_request(input t_kind kind,
                                                    input logic [ADDR_W-1:0] addr);
        t_alloc_result     res;
        int unsigned       limit;
        int unsigned       slot;
        int unsigned       i;
        bit                found;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] idx;

        limit = (count_reg > MAX_CELLS) ? MAX_CELLS : count_reg;
        res.granted_address = '0;
        if (kind == KIND_ALLOC) begin
            found = 1'b0;
            slot  = 0;
            for (i = 0; i < limit; i++) begin
                if (!found && !used_cells[i]) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found) begin
                used_cells[slot]    = 1'b1;
                res.granted_address = base_reg + slot * size_reg;
                res.status          = STATUS_OK;
            end else begin
                res.status = STATUS_FULL;
            end
        end else begin
            offset = addr - base_reg;
            // a zero divisor behaves as an all-ones quotient
            idx = (size_reg == '0) ? '1 : offset / {{(ADDR_W-SIZE_W){1'b0}}, size_reg};
            if (idx < limit) begin
                used_cells[idx] = 1'b0;
                res.status      = STATUS_OK;
            end else begin
                res.status = STATUS_BAD_FREE;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result want;

        if (!i_rst_n) begin
            base_reg   = '0;
            size_reg   = SIZE_W'(1);
            count_reg  = '0;
            used_cells = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE_ADDRESS: base_reg = i_cfg_data;
                    CFG_CELL_SIZE:    size_reg = i_cfg_data[SIZE_W-1:0];
                    CFG_CELL_COUNT:   count_reg = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // results retire before a request accepted at the same edge
            if (i_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: granted_address %h, status %0d",
                           i_granted_address, i_status);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_granted_address !== want.granted_address) begin
                        $error("granted_address mismatch: expected %h, actual %h",
                               want.granted_address, i_granted_address);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(serve_request(i_kind, i_cell_address));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

// ----- dv/bitmap_cell_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_cell_allocator_top_tb: stimulus and verdict for the cell allocator
// Directed corner requests, then randomized phases of alloc and free traffic
// under several register settings, with random start gaps and drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_cell_allocator_top_tb;
    import bca_pkg::*;

    localparam int MAX_CELLS    = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 650;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_start        = 1'b0;
    logic                 i_kind         = KIND_ALLOC;
    logic [ADDR_W-1:0]    i_cell_address = '0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_BASE_ADDRESS;
    logic [ADDR_W-1:0]    i_cfg_data     = '0;

    wire logic              o_busy;
    wire logic              o_valid;
    wire logic [ADDR_W-1:0] o_granted_address;
    wire logic [1:0]        o_status;
    wire logic              o_cfg_ready;

    int fail_count;
    int pending;
    int unsigned cycle_count = 0;

    // register values as last written, used to aim free addresses
    logic [ADDR_W-1:0] cur_base  = '0;
    logic [SIZE_W-1:0] cur_size  = SIZE_W'(1);
    int unsigned       cur_cells = 0;
    bit                idle_enabled = 1'b1;

    bitmap_cell_allocator_top #(
        .MAX_CELLS(MAX_CELLS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_kind            (i_kind),
        .i_cell_address    (i_cell_address),
        .o_valid           (o_valid),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    bitmap_cell_allocator_checker #(
        .MAX_CELLS(MAX_CELLS)
    ) alloc_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_kind            (i_kind),
        .i_cell_address    (i_cell_address),
        .i_valid           (o_valid),
        .i_granted_address (o_granted_address),
        .i_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[bitmap_cell_allocator_top] ERROR");
            $finish;
        end
    end

    // holds start until the transaction is taken, then maybe idles
    task automatic send_request(input t_kind kind, input logic [ADDR_W-1:0] addr);
        i_start        <= 1'b1;
        i_kind         <= kind;
        i_cell_address <= addr;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if (idle_enabled && $urandom_range(99) < 23) begin
            i_start <= 1'b0;
            repeat ($urandom_range(48, 1)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no low cycle
    task automatic write_reg(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size_word,
                             input logic [ADDR_W-1:0] count_word);
        write_reg(CFG_BASE_ADDRESS, base);
        write_reg(CFG_CELL_SIZE, size_word);
        write_reg(CFG_CELL_COUNT, count_word);
        end_writes();
        cur_base  = base;
        cur_size  = size_word[SIZE_W-1:0];
        cur_cells = (count_word[COUNT_W-1:0] > MAX_CELLS) ? MAX_CELLS
                                                          : count_word[COUNT_W-1:0];
    endtask

    // mostly addresses inside live cells, some past the end, below base or wild
    function automatic logic [ADDR_W-1:0] pick_free_address();
        int unsigned       sel;
        int unsigned       slot;
        logic [ADDR_W-1:0] offset;

        sel    = $urandom_range(99);
        offset = (cur_size == '0) ? '0 : $urandom_range(32'(cur_size) - 1);
        slot   = (cur_cells == 0) ? 0 : $urandom_range(cur_cells - 1);
        if (sel < 70)
            return cur_base + slot * cur_size + offset;
        else if (sel < 80)
            return cur_base + cur_cells * cur_size + offset;
        else if (sel < 90)
            return cur_base - $urandom_range(64, 1);
        else
            return $urandom();
    endfunction

    initial begin
        int unsigned       items;
        int unsigned       phase;
        int unsigned       n_items;
        int unsigned       alloc_pct;
        int unsigned       j;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size_word;
        logic [ADDR_W-1:0] count_word;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: no cells, so alloc is full and any free is out of range
        send_request(KIND_ALLOC, '1);
        send_request(KIND_FREE, '0);

        // region wraps past the top of the address space
        wait_for_results();
        configure(32'hFFFF_FFF0, 32'd8, 32'd3);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '1);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, 32'hFFFF_FFFF);
        send_request(KIND_FREE, 32'hFFFF_FFEF);
        send_request(KIND_FREE, 32'h0000_0008);
        send_request(KIND_FREE, 32'hFFFF_FFFF);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, 32'h0000_0000);

        // zero cell size, with junk in the unused upper data bits
        wait_for_results();
        configure(32'h0000_0000, 32'hABCD_0000, 32'h0000_0005);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '1);
        send_request(KIND_FREE, '0);
        send_request(KIND_FREE, '1);

        // unused register index, then largest size and a count above the depth
        wait_for_results();
        write_reg(t_cfg_idx'(3), '1);
        end_writes();
        configure(32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FF7F);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, 32'h1234_5678 + 64 * 32'd65535);
        send_request(KIND_FREE, 32'h1234_5678 + 63 * 32'd65535 + 32'd65534);
        send_request(KIND_ALLOC, '1);

        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS) begin
            wait_for_results();
            base       = $urandom();
            size_word  = ($urandom() & 32'hFFFF_0000) | $urandom_range(16, 1);
            count_word = ($urandom() & 32'hFFFF_FF80) | $urandom_range(8, 1);
            n_items    = $urandom_range(40, 20);
            alloc_pct  = $urandom_range(70, 40);
            idle_enabled = 1'b1;
            case (phase % 6)
                1: begin
                    // fill every row of the bitmap
                    base       = '0;
                    size_word  = 32'd1;
                    count_word = 32'd64;
                    n_items    = 90;
                    alloc_pct  = 80;
                end
                2: begin
                    base       = 32'hFFFF_FF00 | $urandom_range(255);
                    size_word  = 32'hFFFF;
                    count_word = $urandom_range(127, 65);
                    idle_enabled = 1'b0;
                end
                3: begin
                    size_word  = $urandom();
                    count_word = $urandom_range(64);
                end
                4: begin
                    size_word  = (phase % 12 == 4) ? ($urandom() & 32'hFFFF_0000)
                                                   : $urandom_range(4, 1);
                    count_word = $urandom_range(4, 1);
                end
                5: count_word = $urandom_range(16, 1);
                default: ;
            endcase
            configure(base, size_word, count_word);
            for (j = 0; j < n_items; j++) begin
                if ($urandom_range(99) < alloc_pct)
                    send_request(KIND_ALLOC, $urandom());
                else
                    send_request(KIND_FREE, pick_free_address());
                items++;
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
            phase++;
        end

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[bitmap_cell_allocator_top] OK");
        else
            $display("[bitmap_cell_allocator_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
